>>> hw/rtl/eol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eol_pkg
// Shared types and constants of the error log: request codes, the entry
// layout kept in the log memory and the result record of the output buffer.
// ----------------------------------------------------------------------------
package eol_pkg;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef struct packed {
		logic [31:0] tstamp;
		logic [15:0] code;
		logic [7:0]  modid;
		logic [7:0]  flags;
		logic [31:0] data;
	} entry_t;

	typedef struct packed {
		logic [4:0] wpos;
		logic [4:0] rpos;
		logic [5:0] cnt;
	} status_t;

	typedef struct packed {
		entry_t  entry;
		logic    is_entry;
		logic    last;
		status_t status;
	} result_t;

	localparam int MAX_RESULTS = 32;
	localparam int CMP_W       = 7;
	localparam int OBUF_DEPTH  = 4;
	localparam int OBUF_PW     = $clog2(OBUF_DEPTH);
	localparam int OBUF_LW     = $clog2(OBUF_DEPTH + 1);

endpackage
`default_nettype wire

>>> hw/rtl/overwrite_oldest_error_log_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// overwrite_oldest_error_log_unit
// Circular error log of LOG_DEPTH entries that overwrites the oldest entry.
//
// Input channel (in_valid / in_stall) takes one request per transfer: add,
// read (up to max_read oldest entries, left in place) or clear. Output
// channel (out_valid / out_stall) delivers one result per transfer; the last
// result of a request has last_item set. Every result carries the write
// position, read position and fill count after the request.
// Add, clear and unused codes: one result, 1 request per cycle sustained while
// the result queue has room; each result is registered before the queue.
// Read of n entries: n results streamed one per cycle from the log memory
// while the result queue has room; the single memory read port sets this rate.
// An empty read returns one result with is_entry low.
// Reset clears positions and count; log contents stay undefined until added.
// A stalled receiver fills the 4-entry result queue, after which in_stall is
// raised and the read sequence pauses until space frees up.
// ----------------------------------------------------------------------------
module overwrite_oldest_error_log_unit
	import eol_pkg::*;
#(
	parameter int LOG_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] error_code,
	input  wire logic [7:0]  module_id,
	input  wire logic [7:0]  entry_flags,
	input  wire logic [31:0] entry_data,
	input  wire logic [31:0] time_stamp,
	input  wire logic [5:0]  max_read,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [31:0] out_time,
	output      logic [15:0] out_code,
	output      logic [7:0]  out_module,
	output      logic [7:0]  out_flags,
	output      logic [31:0] out_data,
	output      logic        is_entry,
	output      logic        last_item,
	output      logic [4:0]  write_pos,
	output      logic [4:0]  read_pos,
	output      logic [5:0]  fill_count
);

	localparam int PW = $clog2(LOG_DEPTH);
	localparam int CW = $clog2(LOG_DEPTH + 1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(LOG_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [PW-1:0]      head_q, head_d;
	logic [PW-1:0]      tail_q, tail_d;
	logic [CW-1:0]      count_q, count_d;
	logic               busy_q, busy_d;
	logic [PW-1:0]      rdptr_q, rdptr_d;
	logic [5:0]         remain_q, remain_d;

	logic               valid_s1, valid_d;
	logic               is_entry_s1, is_entry_d;
	logic               last_s1, last_d;
	status_t            status_s1, status_d;

	logic [OBUF_LW-1:0] obuf_level;
	logic               room;
	logic               accept;
	logic               beat;
	req_t               req;
	logic               full;
	logic [CMP_W-1:0]   mr_w, cnt_w, n_w;
	logic [5:0]         n_rd;
	entry_t             wr_entry;
	entry_t             rd_entry;
	result_t            push_data;
	result_t            res;

	assign room     = ({1'b0, obuf_level} + (OBUF_LW + 1)'(valid_s1))
	                  < (OBUF_LW + 1)'(OBUF_DEPTH);
	assign in_stall = busy_q || !room;
	assign accept   = in_valid && !in_stall;
	assign beat     = busy_q && room;
	assign req      = req_t'(req_type);
	assign full     = (count_q == CW'(LOG_DEPTH));

	// requested count limited by entries held and by the result cap
	always_comb begin
		mr_w  = CMP_W'(max_read);
		cnt_w = CMP_W'(count_q);
		n_w   = (mr_w < cnt_w) ? mr_w : cnt_w;
		if (n_w > CMP_W'(MAX_RESULTS)) begin
			n_w = CMP_W'(MAX_RESULTS);
		end
		n_rd = n_w[5:0];
	end

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		busy_d     = busy_q;
		rdptr_d    = rdptr_q;
		remain_d   = remain_q;
		valid_d    = 1'b0;
		is_entry_d = 1'b0;
		last_d     = 1'b1;
		if (accept) begin
			valid_d = 1'b1;
			unique case (req)
				REQ_ADD: begin
					head_d = ptr_inc(head_q);
					if (full) begin
						tail_d = ptr_inc(tail_q);
					end else begin
						count_d = count_q + 1'b1;
					end
				end
				REQ_READ: begin
					if (n_rd != '0) begin
						valid_d  = 1'b0;
						busy_d   = 1'b1;
						rdptr_d  = tail_q;
						remain_d = n_rd;
					end
				end
				REQ_CLEAR: begin
					head_d  = '0;
					tail_d  = '0;
					count_d = '0;
				end
				default: begin
				end
			endcase
		end
		if (beat) begin
			valid_d    = 1'b1;
			is_entry_d = 1'b1;
			last_d     = (remain_q == 6'd1);
			rdptr_d    = ptr_inc(rdptr_q);
			remain_d   = remain_q - 1'b1;
			if (remain_q == 6'd1) begin
				busy_d = 1'b0;
			end
		end
		status_d.wpos = 5'(head_d);
		status_d.rpos = 5'(tail_d);
		status_d.cnt  = 6'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			busy_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			busy_q   <= busy_d;
			valid_s1 <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rdptr_q     <= rdptr_d;
		remain_q    <= remain_d;
		is_entry_s1 <= is_entry_d;
		last_s1     <= last_d;
		status_s1   <= status_d;
	end

	// an add writes in its accept cycle; reads run only in the cycles after a
	// read's accept, while no request is taken, so the same entry is never read and written together
	always_comb begin
		wr_entry.tstamp = time_stamp;
		wr_entry.code   = error_code;
		wr_entry.modid  = module_id;
		wr_entry.flags  = entry_flags;
		wr_entry.data   = entry_data;
	end

	eol_ram #(
		.DEPTH (LOG_DEPTH),
		.WIDTH ($bits(entry_t))
	) u_ram (
		.clk   (clk),
		.we    (accept && (req == REQ_ADD)),
		.waddr (head_q),
		.wdata (wr_entry),
		.re    (beat),
		.raddr (rdptr_q),
		.rdata (rd_entry)
	);

	always_comb begin
		push_data.entry    = is_entry_s1 ? rd_entry : '0;
		push_data.is_entry = is_entry_s1;
		push_data.last     = last_s1;
		push_data.status   = status_s1;
	end

	eol_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (push_data),
		.level     (obuf_level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res)
	);

	assign out_time   = res.entry.tstamp;
	assign out_code   = res.entry.code;
	assign out_module = res.entry.modid;
	assign out_flags  = res.entry.flags;
	assign out_data   = res.entry.data;
	assign is_entry   = res.is_entry;
	assign last_item  = res.last;
	assign write_pos  = res.status.wpos;
	assign read_pos   = res.status.rpos;
	assign fill_count = res.status.cnt;

endmodule
`default_nettype wire

>>> hw/rtl/eol_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eol_ram
// Simple dual-port log memory: one write port, one read port and registered
// read data.
// ----------------------------------------------------------------------------
module eol_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 96
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/eol_obuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eol_obuf
// Small result queue in front of the output channel. Reports its fill level
// so the sequencer only starts a result when a slot is guaranteed.
// ----------------------------------------------------------------------------
module eol_obuf
	import eol_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire result_t            push_data,
	output      logic [OBUF_LW-1:0] level,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      result_t            out_data
);

	result_t              buf_q [OBUF_DEPTH];
	logic [OBUF_PW-1:0]   wr_ptr_q;
	logic [OBUF_PW-1:0]   rd_ptr_q;
	logic [OBUF_LW-1:0]   level_q;
	logic                 pop;

	assign out_valid = (level_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = buf_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for overwrite_oldest_error_log_unit. A short table of
// requests covers reset state, field extremes, empty and oversized reads,
// clears and the unused request code. Random traffic then fills the log past
// full so that it wraps. Random request gaps, random receiver stalls and one long receiver
// hold-off exercise back-pressure. Every result is compared against an
// in-bench copy of the log.
// ----------------------------------------------------------------------------
module tb;
	import eol_pkg::*;

	localparam int LOG_DEPTH     = 32;
	localparam int STUCK_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 213;

	typedef struct {
		req_t        req;
		logic [15:0] code;
		logic [7:0]  modid;
		logic [7:0]  flags;
		logic [31:0] data;
		logic [31:0] tstamp;
		logic [5:0]  maxr;
		bit          typed;
		int          wpos;
		int          rpos;
		int          cnt;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_NONE;
	logic [15:0] error_code = '0;
	logic [7:0]  module_id = '0;
	logic [7:0]  entry_flags = '0;
	logic [31:0] entry_data = '0;
	logic [31:0] time_stamp = '0;
	logic [5:0]  max_read = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] out_time;
	logic [15:0] out_code;
	logic [7:0]  out_module;
	logic [7:0]  out_flags;
	logic [31:0] out_data;
	logic        is_entry;
	logic        last_item;
	logic [4:0]  write_pos;
	logic [4:0]  read_pos;
	logic [5:0]  fill_count;

	// copy of the log and the results it predicts
	entry_t  log_copy [LOG_DEPTH];
	int      head_idx, tail_idx, held_entries;
	result_t log_replies [$];

	int  errors, replies_seen, entries_seen, stuck_cycles;
	int  n_add, n_read, n_clear, n_unused, n_overwrite;
	bit  quiet, long_hold_pending;
	request_t directed_rows [$];

	overwrite_oldest_error_log_unit #(.LOG_DEPTH(LOG_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .error_code(error_code), .module_id(module_id),
		.entry_flags(entry_flags), .entry_data(entry_data), .time_stamp(time_stamp),
		.max_read(max_read),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_time(out_time), .out_code(out_code), .out_module(out_module),
		.out_flags(out_flags), .out_data(out_data),
		.is_entry(is_entry), .last_item(last_item),
		.write_pos(write_pos), .read_pos(read_pos), .fill_count(fill_count)
	);

	always #1 clk = ~clk;

	function automatic request_t row(req_t rq, logic [15:0] c, logic [7:0] m,
			logic [7:0] f, logic [31:0] d, logic [31:0] t, logic [5:0] mr,
			bit typed = 1'b0, int wp = 0, int rp = 0, int cn = 0);
		request_t s;
		s.req = rq; s.code = c; s.modid = m; s.flags = f;
		s.data = d; s.tstamp = t; s.maxr = mr;
		s.typed = typed; s.wpos = wp; s.rpos = rp; s.cnt = cn;
		return s;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic queue_reply(input bit entry, input int idx, input bit last);
		result_t r;
		r = '0;
		if (entry)
			r.entry = log_copy[idx];
		r.is_entry    = entry;
		r.last        = last;
		r.status.wpos = head_idx[4:0];
		r.status.rpos = tail_idx[4:0];
		r.status.cnt  = held_entries[5:0];
		log_replies.push_back(r);
	endtask

	task automatic apply_to_log(input request_t s);
		int n, p;
		case (s.req)
			REQ_ADD: begin
				n_add++;
				if (held_entries >= LOG_DEPTH) begin
					tail_idx = (tail_idx + 1) % LOG_DEPTH;
					n_overwrite++;
				end
				log_copy[head_idx].tstamp = s.tstamp;
				log_copy[head_idx].code   = s.code;
				log_copy[head_idx].modid  = s.modid;
				log_copy[head_idx].flags  = s.flags;
				log_copy[head_idx].data   = s.data;
				head_idx = (head_idx + 1) % LOG_DEPTH;
				if (held_entries < LOG_DEPTH)
					held_entries++;
				queue_reply(1'b0, 0, 1'b1);
			end
			REQ_READ: begin
				n_read++;
				n = int'(s.maxr);
				if (n > held_entries)
					n = held_entries;
				if (n > MAX_RESULTS)
					n = MAX_RESULTS;
				p = tail_idx;
				if (n == 0)
					queue_reply(1'b0, 0, 1'b1);
				for (int k = 0; k < n; k++) begin
					queue_reply(1'b1, p, k == n - 1);
					p = (p + 1) % LOG_DEPTH;
				end
			end
			REQ_CLEAR: begin
				n_clear++;
				head_idx = 0;
				tail_idx = 0;
				held_entries = 0;
				queue_reply(1'b0, 0, 1'b1);
			end
			default: begin
				n_unused++;
				queue_reply(1'b0, 0, 1'b1);
			end
		endcase
	endtask

	// offer one request and hold it until the transfer happens
	task automatic send(input request_t s);
		result_t t;
		in_valid    <= 1'b1;
		req_type    <= s.req;
		error_code  <= s.code;
		module_id   <= s.modid;
		entry_flags <= s.flags;
		entry_data  <= s.data;
		time_stamp  <= s.tstamp;
		max_read    <= s.maxr;
		do @(posedge clk); while (in_stall !== 1'b0);
		apply_to_log(s);
		if (s.typed) begin
			t = '0;
			t.last        = 1'b1;
			t.status.wpos = s.wpos[4:0];
			t.status.rpos = s.rpos[4:0];
			t.status.cnt  = s.cnt[5:0];
			log_replies[log_replies.size() - 1] = t;
		end
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (log_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("result %0d: %s got %h want %h",
				replies_seen, name, got, want));
	endtask

	task automatic check_reply();
		result_t w;
		if (log_replies.size() == 0) begin
			report_error($sformatf("result %0d arrived with nothing expected",
				replies_seen));
		end else begin
			w = log_replies.pop_front();
			cmp_field("out_time", out_time, w.entry.tstamp);
			cmp_field("out_code", 32'(out_code), 32'(w.entry.code));
			cmp_field("out_module", 32'(out_module), 32'(w.entry.modid));
			cmp_field("out_flags", 32'(out_flags), 32'(w.entry.flags));
			cmp_field("out_data", out_data, w.entry.data);
			cmp_field("is_entry", 32'(is_entry), 32'(w.is_entry));
			cmp_field("last_item", 32'(last_item), 32'(w.last));
			cmp_field("write_pos", 32'(write_pos), 32'(w.status.wpos));
			cmp_field("read_pos", 32'(read_pos), 32'(w.status.rpos));
			cmp_field("fill_count", 32'(fill_count), 32'(w.status.cnt));
			if (w.is_entry)
				entries_seen++;
		end
		replies_seen++;
	endtask

	// receiving side: checks each transfer and drives out_stall
	initial begin : rx_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				check_reply();
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				stall_left = 80;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 14);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d results outstanding",
				stuck_cycles, log_replies.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		request_t s;
		int pick;
		bit fill;

		head_idx = 0;
		tail_idx = 0;
		held_entries = 0;

		directed_rows.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 5, 1, 0, 0, 0));
		directed_rows.push_back(row(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		directed_rows.push_back(row(REQ_NONE, '1, '1, '1, '1, '1, '1, 1, 0, 0, 0));
		directed_rows.push_back(row(REQ_ADD, '1, '1, '1, '1, '1, '1, 1, 1, 0, 1));
		directed_rows.push_back(row(REQ_ADD, 0, 0, 0, 0, 0, 0, 1, 2, 0, 2));
		directed_rows.push_back(row(REQ_READ, '1, '1, '1, '1, '1, 0, 1, 2, 0, 2));
		directed_rows.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 6'd63));
		directed_rows.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 6'd1));
		directed_rows.push_back(row(REQ_ADD, 16'hA5A5, 8'hA5, 8'h5A, 32'hA5A5A5A5,
			32'h5A5A5A5A, 6'h2A));
		directed_rows.push_back(row(REQ_ADD, 16'h5A5A, 8'h5A, 8'hA5, 32'h5A5A5A5A,
			32'hA5A5A5A5, 6'h15));
		directed_rows.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 6'd32));
		directed_rows.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 6'd3));
		directed_rows.push_back(row(REQ_NONE, 0, 0, 0, 0, 0, 6'd1, 1, 4, 0, 4));
		directed_rows.push_back(row(REQ_CLEAR, '1, '1, '1, '1, '1, '1, 1, 0, 0, 0));
		directed_rows.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 6'd32, 1, 0, 0, 0));
		directed_rows.push_back(row(REQ_ADD, 16'h1234, 8'h56, 8'h78, 32'h9ABCDEF0,
			32'h00000100, 0));
		directed_rows.push_back(row(REQ_READ, 0, 0, 0, 0, 0, 6'd2));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			send(directed_rows[r]);
			maybe_idle();
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 190);
			fill  = (i < 50) || (i >= 100 && i < 150);
			pick  = $urandom_range(0, 99);
			s = row(REQ_ADD, 16'($urandom), 8'($urandom), 8'($urandom), $urandom,
				$urandom, 6'd0);
			case ($urandom_range(0, 9))
				0:             s.maxr = 6'd0;
				1, 2, 3, 4:    s.maxr = 6'($urandom_range(1, 8));
				5, 6, 7:       s.maxr = 6'($urandom_range(9, 32));
				default:       s.maxr = 6'($urandom_range(33, 63));
			endcase
			if (i == 30)
				long_hold_pending = 1'b1;
			if (i == 100) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			if (i >= 30 && i < 36)
				s.req = REQ_READ;
			else if (i == 100)
				s.req = REQ_CLEAR;
			else if (pick < 4)
				s.req = REQ_NONE;
			else if (pick < 6 && !fill)
				s.req = REQ_CLEAR;
			else if (pick < (fill ? 85 : 50))
				s.req = REQ_ADD;
			else
				s.req = REQ_READ;
			send(s);
			maybe_idle();
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		$display("covered %0d adds (%0d overwrote the oldest entry), %0d reads,",
			n_add, n_overwrite, n_read);
		$display("%0d clears, %0d unused codes; checked %0d results, %0d entries, %0d mismatches",
			n_clear, n_unused, replies_seen, entries_seen, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
